[hdl/mlp_pkg.sv]
package mlp_pkg;

    // network shape
    localparam int NUM_FEATURES = 4;
    localparam int NUM_HIDDEN   = 4;
    localparam int NUM_OUTPUTS  = 3;
    localparam int HID_COUNT    = (NUM_FEATURES + 1) * NUM_HIDDEN;
    localparam int OUT_COUNT    = (NUM_HIDDEN + 1) * NUM_OUTPUTS;
    localparam int WMEM_DEPTH   = HID_COUNT + OUT_COUNT;
    localparam int WADDR_W      = $clog2(WMEM_DEPTH);
    localparam int FI_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int HI_W = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
    localparam int OI_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam int CNT_W = 5;

    // arithmetic widths
    localparam int OP_W  = 25;
    localparam int ACC_W = 56;

    // commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EVAL  = 2'd1;
    localparam logic [1:0] CMD_TRAIN = 2'd2;

    localparam logic [16:0] LR_RESET = 17'd16384;
    localparam logic signed [OP_W-1:0] MINUS_ONE = -25'sd65536;
    localparam logic signed [OP_W-1:0] ONE_Q16   = 25'sd65536;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [23:0] feature_0;
        logic signed [23:0] feature_1;
        logic signed [23:0] feature_2;
        logic signed [23:0] feature_3;
        logic [16:0]        target_0;
        logic [16:0]        target_1;
        logic [16:0]        target_2;
        logic [5:0]         weight_index;
        logic signed [23:0] weight_value;
    } req_t;

    typedef struct packed {
        logic [16:0] score_0;
        logic [16:0] score_1;
        logic [16:0] score_2;
    } rsp_t;

    // MAC control: en steps the accumulator, clr starts from the init value
    typedef struct packed {
        logic en;
        logic clr;
    } mac_ctl_t;

    typedef logic [16:0] sig_rom_t [256];

    // sigmoid table over -8 up to 127/16 in 1/16 steps, built at elaboration
    function automatic sig_rom_t build_sig_rom();
        logic [95:0] e [129];
        logic [95:0] d;
        logic [95:0] num;
        logic [95:0] rem;
        logic [95:0] q;
        int          t;
        sig_rom_t    rom;
        e[0] = 96'd1 << 32;
        for (int i = 1; i <= 128; i++) begin
            e[i] = (e[i-1] * 96'd4034748382 + (96'd1 << 31)) >> 32;
        end
        for (int k = 0; k < 256; k++) begin
            t   = (k >= 128) ? k - 128 : 128 - k;
            d   = (96'd1 << 32) + e[t];
            num = (k >= 128) ? (96'd1 << 48) : (e[t] << 16);
            num = num + (d >> 1);
            rem = '0;
            q   = '0;
            // restoring long division
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[94:0], num[b]};
                if (rem >= d) begin
                    rem  = rem - d;
                    q[b] = 1'b1;
                end
            end
            rom[k] = q[16:0];
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

    // v is the Q.16 sum shifted right by 12 more bits
    function automatic logic [16:0] sigmoid(input logic signed [27:0] v);
        logic [7:0] idx;
        if (v < -28'sd128)
            idx = 8'd0;
        else if (v > 28'sd127)
            idx = 8'd255;
        else
            idx = v[7:0] + 8'd128;
        return SIG_ROM[idx];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        if (v > 40'sd8388607)
            return 24'sd8388607;
        else if (v < -40'sd8388608)
            return -24'sd8388608;
        else
            return v[23:0];
    endfunction

endpackage

[hdl/mlp_mac.sv]
module mlp_mac (
    input  logic                             clk,
    input  mlp_pkg::mac_ctl_t                ctl,
    input  logic signed [mlp_pkg::OP_W-1:0]  a,
    input  logic signed [mlp_pkg::OP_W-1:0]  b,
    input  logic signed [mlp_pkg::ACC_W-1:0] init,
    output logic signed [mlp_pkg::ACC_W-1:0] acc
);
    import mlp_pkg::*;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [2*OP_W-1:0] prod;

    assign prod = a * b;
    assign acc  = acc_reg;

    // shared multiply-accumulate
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= (ctl.clr ? init : acc_reg) + ACC_W'(prod);
        end
    end

endmodule

[hdl/mlp_wmem.sv]
module mlp_wmem (
    input  logic                             clk,
    input  logic                             we,
    input  logic [mlp_pkg::WADDR_W-1:0]      waddr,
    input  logic signed [23:0]               wdata,
    input  logic [mlp_pkg::WADDR_W-1:0]      raddr,
    output logic signed [23:0]               rdata
);
    import mlp_pkg::*;

    logic signed [23:0] mem [WMEM_DEPTH];
    logic signed [23:0] rdata_reg;

    assign rdata = rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

[hdl/mlp_two_layer_backprop.sv]
// Two-layer sigmoid perceptron with on-chip backpropagation training.
// Request channel (req_valid / req_stall / req): a transfer happens when
// req_valid is high and req_stall is low. cmd 0 writes one weight, cmd 1
// evaluates, cmd 2 evaluates then trains; cmd 3 is dropped.
// Response channel (rsp_valid / rsp_stall / rsp) carries the three scores
// of cmd 1 and cmd 2; a write command gives no response.
// All arithmetic runs through one multiply-accumulate unit, with the weight
// store read one term at a time, so req_stall stays high while an item is
// worked on. rsp_valid rises after the hidden pass, the output pass and the
// load of the response register; an evaluation frees the block then.
// A training item then holds the block through the output deltas, the hidden
// deltas and the two update passes, output layer first.
// The response sits in an output register; a stalled receiver only delays
// the block when the next result is ready before the last was taken.
// The learning rate is written through lr_we / lr_wdata while idle, a rule
// for the user that the block does not enforce. Reset clears control and sets
// the learning rate to 0.25; weights are undefined until software loads all.
module mlp_two_layer_backprop (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                lr_we,
    input  logic [16:0]         lr_wdata,
    input  logic                req_valid,
    output logic                req_stall,
    input  mlp_pkg::req_t       req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mlp_pkg::rsp_t       rsp
);
    import mlp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HID  = 4'd1;
    localparam logic [3:0] S_OUT  = 4'd2;
    localparam logic [3:0] S_RES  = 4'd3;
    localparam logic [3:0] S_D1   = 4'd4;
    localparam logic [3:0] S_BP   = 4'd5;
    localparam logic [3:0] S_UO   = 4'd6;
    localparam logic [3:0] S_UH   = 4'd7;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] o_reg;
    logic [CNT_W-1:0] n_reg;
    logic [2:0]       sub_reg;
    logic [16:0]      lr_reg;
    logic             train_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic signed [23:0] x_reg   [NUM_FEATURES];
    logic [16:0]        t_reg   [NUM_OUTPUTS];
    logic [16:0]        h_reg   [NUM_HIDDEN];
    logic [16:0]        y_reg   [NUM_OUTPUTS];
    logic signed [23:0] d1_reg  [NUM_OUTPUTS];
    logic signed [23:0] d0_reg  [NUM_HIDDEN];
    logic signed [23:0] bp_reg;
    logic signed [23:0] lrd_reg;

    mac_ctl_t                 mac_ctl;
    logic signed [OP_W-1:0]   mac_a, mac_b;
    logic signed [ACC_W-1:0]  mac_init, acc;
    logic                     mem_we;
    logic [WADDR_W-1:0]       mem_waddr, mem_raddr, addr;
    logic signed [23:0]       mem_wdata, rdata;
    logic                     req_xfer;
    logic signed [23:0]       acc_sat;
    logic [16:0]              acc_sig;
    logic signed [OP_W-1:0]   acc_der;
    logic signed [OP_W-1:0]   xval, hval;
    logic                     n_last_x, n_last_h, n_last_o;

    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign acc_sat = sat24(acc[55:16]);
    assign acc_sig = sigmoid(acc[55:28]);
    assign acc_der = acc[OP_W+15:16];

    assign n_last_x = (n_reg == CNT_W'(NUM_FEATURES));
    assign n_last_h = (n_reg == CNT_W'(NUM_HIDDEN));
    assign n_last_o = (n_reg == CNT_W'(NUM_OUTPUTS - 1));

    // layer inputs with the bias input at the end
    always_comb
    begin
        xval = MINUS_ONE;
        hval = MINUS_ONE;
        if (n_reg < CNT_W'(NUM_FEATURES))
            xval = OP_W'(x_reg[n_reg[FI_W-1:0]]);
        if (n_reg < CNT_W'(NUM_HIDDEN))
            hval = $signed({8'b0, h_reg[n_reg[HI_W-1:0]]});
    end

    // weight address for the current term
    always_comb
    begin
        case (state_reg)
            S_HID, S_UH:
                addr = WADDR_W'(n_reg * NUM_HIDDEN) + WADDR_W'(o_reg);
            S_BP:
                addr = WADDR_W'(HID_COUNT) + WADDR_W'(o_reg * NUM_OUTPUTS)
                     + WADDR_W'(n_reg);
            default:
                addr = WADDR_W'(HID_COUNT) + WADDR_W'(n_reg * NUM_OUTPUTS)
                     + WADDR_W'(o_reg);
        endcase
    end

    // operand selection and memory port control
    always_comb
    begin
        mac_ctl   = '0;
        mac_a     = '0;
        mac_b     = '0;
        mac_init  = '0;
        mem_raddr = addr;
        mem_we    = 1'b0;
        mem_waddr = addr;
        mem_wdata = acc_sat;
        if (req_xfer && req.cmd == CMD_WRITE && req.weight_index < 6'(WMEM_DEPTH))
        begin
            mem_we    = 1'b1;
            mem_waddr = req.weight_index[WADDR_W-1:0];
            mem_wdata = req.weight_value;
        end
        case (state_reg)
            S_HID:
            begin
                if (sub_reg == 3'd1)
                begin
                    mac_ctl = '{en: 1'b1, clr: (n_reg == '0)};
                    mac_a   = xval;
                    mac_b   = OP_W'(rdata);
                end
            end
            S_OUT:
            begin
                if (sub_reg == 3'd1)
                begin
                    mac_ctl = '{en: 1'b1, clr: (n_reg == '0)};
                    mac_a   = hval;
                    mac_b   = OP_W'(rdata);
                end
            end
            S_D1:
            begin
                if (sub_reg == 3'd0)
                begin
                    mac_ctl = '{en: 1'b1, clr: 1'b1};
                    mac_a   = $signed({8'b0, y_reg[o_reg[OI_W-1:0]]});
                    mac_b   = ONE_Q16 - $signed({8'b0, y_reg[o_reg[OI_W-1:0]]});
                end
                else if (sub_reg == 3'd1)
                begin
                    mac_ctl = '{en: 1'b1, clr: 1'b1};
                    mac_a   = $signed({8'b0, t_reg[o_reg[OI_W-1:0]]})
                            - $signed({8'b0, y_reg[o_reg[OI_W-1:0]]});
                    mac_b   = acc_der;
                end
            end
            S_BP:
            begin
                if (sub_reg == 3'd1)
                begin
                    mac_ctl = '{en: 1'b1, clr: (n_reg == '0)};
                    mac_a   = OP_W'(rdata);
                    mac_b   = OP_W'(d1_reg[n_reg[OI_W-1:0]]);
                end
                else if (sub_reg == 3'd2)
                begin
                    mac_ctl = '{en: 1'b1, clr: 1'b1};
                    mac_a   = $signed({8'b0, h_reg[o_reg[HI_W-1:0]]});
                    mac_b   = ONE_Q16 - $signed({8'b0, h_reg[o_reg[HI_W-1:0]]});
                end
                else if (sub_reg == 3'd3)
                begin
                    mac_ctl = '{en: 1'b1, clr: 1'b1};
                    mac_a   = acc_der;
                    mac_b   = OP_W'(bp_reg);
                end
            end
            S_UO, S_UH:
            begin
                if (sub_reg == 3'd0)
                begin
                    mac_ctl = '{en: 1'b1, clr: 1'b1};
                    mac_a   = $signed({8'b0, lr_reg});
                    mac_b   = (state_reg == S_UO) ? OP_W'(d1_reg[o_reg[OI_W-1:0]])
                                                  : OP_W'(d0_reg[o_reg[HI_W-1:0]]);
                end
                else if (sub_reg == 3'd3)
                begin
                    mac_ctl  = '{en: 1'b1, clr: 1'b1};
                    mac_a    = OP_W'(lrd_reg);
                    mac_b    = (state_reg == S_UO) ? hval : xval;
                    mac_init = ACC_W'(rdata) <<< 16;
                end
                else if (sub_reg == 3'd4)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = addr;
                    mem_wdata = acc_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req_xfer && (req.cmd == CMD_EVAL || req.cmd == CMD_TRAIN))
                    state_next = S_HID;
            S_HID:
                if (sub_reg == 3'd2 && o_reg == CNT_W'(NUM_HIDDEN - 1))
                    state_next = S_OUT;
            S_OUT:
                if (sub_reg == 3'd2 && o_reg == CNT_W'(NUM_OUTPUTS - 1))
                    state_next = S_RES;
            S_RES:
                if (!(rsp_valid_reg && rsp_stall))
                    state_next = train_reg ? S_D1 : S_IDLE;
            S_D1:
                if (sub_reg == 3'd2 && o_reg == CNT_W'(NUM_OUTPUTS - 1))
                    state_next = S_BP;
            S_BP:
                if (sub_reg == 3'd4 && o_reg == CNT_W'(NUM_HIDDEN - 1))
                    state_next = S_UO;
            S_UO:
                if (sub_reg == 3'd4 && n_last_h && o_reg == CNT_W'(NUM_OUTPUTS - 1))
                    state_next = S_UH;
            S_UH:
                if (sub_reg == 3'd4 && n_last_x && o_reg == CNT_W'(NUM_HIDDEN - 1))
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            o_reg         <= '0;
            n_reg         <= '0;
            sub_reg       <= '0;
            lr_reg        <= LR_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (lr_we)
                lr_reg <= lr_wdata;
            // response load wins over the transfer of the previous one
            if (state_reg == S_RES && !(rsp_valid_reg && rsp_stall))
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    o_reg   <= '0;
                    n_reg   <= '0;
                    sub_reg <= '0;
                end
                S_HID, S_OUT:
                begin
                    if (sub_reg == 3'd0)
                        sub_reg <= 3'd1;
                    else if (sub_reg == 3'd1)
                    begin
                        if ((state_reg == S_HID) ? n_last_x : n_last_h)
                            sub_reg <= 3'd2;
                        else
                        begin
                            n_reg   <= n_reg + 1'b1;
                            sub_reg <= 3'd0;
                        end
                    end
                    else
                    begin
                        n_reg   <= '0;
                        sub_reg <= 3'd0;
                        if (state_next != state_reg)
                            o_reg <= '0;
                        else
                            o_reg <= o_reg + 1'b1;
                    end
                end
                S_RES:
                begin
                end
                S_D1:
                begin
                    if (sub_reg == 3'd2)
                    begin
                        sub_reg <= 3'd0;
                        o_reg   <= (state_next != state_reg) ? '0 : o_reg + 1'b1;
                    end
                    else
                        sub_reg <= sub_reg + 1'b1;
                end
                S_BP:
                begin
                    if (sub_reg == 3'd0)
                        sub_reg <= 3'd1;
                    else if (sub_reg == 3'd1)
                    begin
                        if (n_last_o)
                        begin
                            n_reg   <= '0;
                            sub_reg <= 3'd2;
                        end
                        else
                        begin
                            n_reg   <= n_reg + 1'b1;
                            sub_reg <= 3'd0;
                        end
                    end
                    else if (sub_reg == 3'd4)
                    begin
                        sub_reg <= 3'd0;
                        o_reg   <= (state_next != state_reg) ? '0 : o_reg + 1'b1;
                    end
                    else
                        sub_reg <= sub_reg + 1'b1;
                end
                S_UO, S_UH:
                begin
                    if (sub_reg == 3'd1)
                    begin
                        n_reg   <= '0;
                        sub_reg <= 3'd2;
                    end
                    else if (sub_reg == 3'd4)
                    begin
                        if ((state_reg == S_UO) ? n_last_h : n_last_x)
                        begin
                            n_reg   <= '0;
                            sub_reg <= 3'd0;
                            o_reg   <= (state_next != state_reg) ? '0 : o_reg + 1'b1;
                        end
                        else
                        begin
                            n_reg   <= n_reg + 1'b1;
                            sub_reg <= 3'd2;
                        end
                    end
                    else
                        sub_reg <= sub_reg + 1'b1;
                end
                default:
                begin
                    sub_reg <= '0;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            train_reg <= (req.cmd == CMD_TRAIN);
            x_reg[0]  <= req.feature_0;
            x_reg[1]  <= req.feature_1;
            x_reg[2]  <= req.feature_2;
            x_reg[3]  <= req.feature_3;
            t_reg[0]  <= req.target_0;
            t_reg[1]  <= req.target_1;
            t_reg[2]  <= req.target_2;
        end
        if (state_reg == S_HID && sub_reg == 3'd2)
            h_reg[o_reg[HI_W-1:0]] <= acc_sig;
        if (state_reg == S_OUT && sub_reg == 3'd2)
            y_reg[o_reg[OI_W-1:0]] <= acc_sig;
        if (state_reg == S_RES && !(rsp_valid_reg && rsp_stall))
        begin
            rsp_reg.score_0 <= y_reg[0];
            rsp_reg.score_1 <= y_reg[1];
            rsp_reg.score_2 <= y_reg[2];
        end
        if (state_reg == S_D1 && sub_reg == 3'd2)
            d1_reg[o_reg[OI_W-1:0]] <= acc_sat;
        if (state_reg == S_BP && sub_reg == 3'd2)
            bp_reg <= acc_sat;
        if (state_reg == S_BP && sub_reg == 3'd4)
            d0_reg[o_reg[HI_W-1:0]] <= acc_sat;
        if ((state_reg == S_UO || state_reg == S_UH) && sub_reg == 3'd1)
            lrd_reg <= acc_sat;
    end

    mlp_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .a    (mac_a),
        .b    (mac_b),
        .init (mac_init),
        .acc  (acc)
    );

    mlp_wmem u_wmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    // weight updates only come from the training passes
    a_upd_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_IDLE) |-> (state_reg == S_UO || state_reg == S_UH))
        else $error("weight write outside update pass");

    // leaving the result state always leaves a response on the port
    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RES && !(rsp_valid_reg && rsp_stall)) |=> rsp_valid)
        else $error("response not loaded");

    // inner term counter never runs past the longest row
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg <= CNT_W'(NUM_FEATURES) || n_reg <= CNT_W'(NUM_HIDDEN)))
        else $error("term counter out of range");

    // an evaluation only starts after a request transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HID && $past(state_reg) == S_IDLE) |-> $past(req_xfer))
        else $error("evaluation started without a request");

endmodule
